// ===== rtl/wvp_pkg.sv =====
// Shared types, codes and defaults for the weighted variant picker.
package wvp_pkg;

  localparam int SOUND_ENTRIES_DEF = 64;
  localparam int MAX_VARIANTS_DEF  = 8;
  localparam int WEIGHT_BITS_DEF   = 8;

  localparam int IDX_W   = 6;
  localparam int MODE_W  = 2;
  localparam int CNTIN_W = 4;
  localparam int PACK_W  = 64;
  localparam int RND_W   = 64;
  localparam int VAR_W   = 3;

  localparam logic REQ_DECLARE = 1'b0;
  localparam logic REQ_PICK    = 1'b1;

  localparam logic [MODE_W-1:0] MODE_SEQ       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NO_REPEAT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ZERO_TOTAL   = 2'd1,
    ST_NOT_DECLARED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SUM,
    S_CHK,
    S_DIV,
    S_SCAN,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    RES_NOT_DECLARED,
    RES_ZERO_TOTAL,
    RES_DECLARED,
    RES_SEQ,
    RES_SCAN
  } res_kind_e;

  typedef struct packed {
    logic      clr_wr;
    logic      cap_req;
    logic      wr_decl;
    logic      wr_seq;
    logic      wr_pick;
    logic      sum_init;
    logic      sum_step;
    logic      div_init;
    logic      div_step;
    logic      scan_step;
    logic      res_en;
    res_kind_e res_kind;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic is_pick;
    logic declared;
    logic mode_seq;
    logic sum_last;
    logic total_zero;
    logic div_last;
    logic scan_hit;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/wvp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wvp_ram import wvp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = SOUND_ENTRIES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wvp_ctrl.sv =====
// Controller state machine: sequences lookup, weight sum, modulo and scan.
module wvp_ctrl import wvp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_LOOK;
      S_LOOK: begin
        priority if (!stat_i.in_range || !stat_i.is_pick || !stat_i.declared ||
                     stat_i.mode_seq) begin
          state_d = S_RESP;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM:  if (stat_i.sum_last) state_d = S_CHK;
      S_CHK:  state_d = stat_i.total_zero ? S_RESP : S_DIV;
      S_DIV:  if (stat_i.div_last) state_d = S_SCAN;
      S_SCAN: if (stat_i.scan_hit) state_d = S_RESP;
      S_RESP: if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_kind = RES_NOT_DECLARED;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.cap_req = in_valid_i;
      end
      S_LOOK: begin
        priority if (!stat_i.in_range) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_NOT_DECLARED;
        end else if (!stat_i.is_pick) begin
          cmd_o.wr_decl  = 1'b1;
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_DECLARED;
        end else if (!stat_i.declared) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_NOT_DECLARED;
        end else if (stat_i.mode_seq) begin
          cmd_o.wr_seq   = 1'b1;
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_SEQ;
        end else begin
          cmd_o.sum_init = 1'b1;
        end
      end
      S_SUM: cmd_o.sum_step = 1'b1;
      S_CHK: begin
        if (stat_i.total_zero) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_ZERO_TOTAL;
        end else begin
          cmd_o.div_init = 1'b1;
        end
      end
      S_DIV: cmd_o.div_step = 1'b1;
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_hit) begin
          cmd_o.wr_pick  = 1'b1;
          cmd_o.res_en   = 1'b1;
          cmd_o.res_kind = RES_SCAN;
        end
      end
      S_RESP: cmd_o.load_out = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/wvp_dp.sv =====
// Datapath: entry tables, weight accumulator, restoring divider, scan, output register.
module wvp_dp import wvp_pkg::*; #(
  parameter int SOUND_ENTRIES = SOUND_ENTRIES_DEF,
  parameter int MAX_VARIANTS  = MAX_VARIANTS_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               req_type_i,
  input  logic [IDX_W-1:0]   sound_index_i,
  input  logic [MODE_W-1:0]  select_mode_i,
  input  logic [CNTIN_W-1:0] variant_count_i,
  input  logic [PACK_W-1:0]  packed_weights_i,
  input  logic [RND_W-1:0]   random_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VAR_W-1:0]   picked_variant_o,
  output logic [1:0]         status_o
);

  localparam int AW    = (SOUND_ENTRIES > 1) ? $clog2(SOUND_ENTRIES) : 1;
  localparam int VW    = (MAX_VARIANTS > 1) ? $clog2(MAX_VARIANTS) : 1;
  localparam int CNT_W = $clog2(MAX_VARIANTS + 1);
  localparam int TOT_W = WEIGHT_BITS + CNT_W;
  localparam int BC_W  = $clog2(RND_W);

  // entry word layout
  localparam int E_LV      = 0;
  localparam int E_LAST_LO = 1;
  localparam int E_NSEQ_LO = E_LAST_LO + VW;
  localparam int E_W_LO    = E_NSEQ_LO + VW;
  localparam int E_CNT_LO  = E_W_LO + PACK_W;
  localparam int E_MODE_LO = E_CNT_LO + CNT_W;
  localparam int ENTRY_W   = E_MODE_LO + MODE_W;

  // captured request
  logic               req_q;
  logic [IDX_W-1:0]   idx_q;
  logic [MODE_W-1:0]  mode_in_q;
  logic [CNT_W-1:0]   cnt_in_q;
  logic [PACK_W-1:0]  wts_in_q;
  logic [RND_W-1:0]   rnd_q, rnd_d;

  // iteration state
  logic [AW-1:0]      clr_q;
  logic [VW-1:0]      v_q, v_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [TOT_W-1:0]   rem_q, rem_d;
  logic [BC_W-1:0]    bit_q, bit_d;

  // result and output
  status_e            res_st_q;
  logic [VAR_W-1:0]   res_var_q;
  logic               out_valid_q, out_valid_d;
  status_e            out_st_q;
  logic [VAR_W-1:0]   out_var_q;

  logic [ENTRY_W-1:0] ent_rd, ent_wd;
  logic               flag_rd;
  logic               ent_we, flag_we, flag_wd;
  logic [AW-1:0]      addr_in, addr_q, flag_waddr;

  logic [MODE_W-1:0]  e_mode;
  logic [CNT_W-1:0]   e_cnt;
  logic [PACK_W-1:0]  e_wts;
  logic [VW-1:0]      e_nseq, e_last;
  logic               e_lv;

  logic [4:0]         cnt_ext, cnt_clamp;
  logic [VW-1:0]      seq_pick, seq_next;
  logic               avoid;
  logic [7:0]         shamt;
  logic [PACK_W-1:0]  shifted;
  logic [WEIGHT_BITS-1:0] w_raw, w_eff;
  logic [TOT_W:0]     trial;
  logic               v_last;

  assign addr_in    = AW'(sound_index_i);
  assign addr_q     = AW'(idx_q);
  assign flag_we    = cmd_i.clr_wr | cmd_i.wr_decl;
  assign flag_waddr = cmd_i.clr_wr ? clr_q : addr_q;
  assign flag_wd    = cmd_i.wr_decl;
  assign ent_we     = cmd_i.wr_decl | cmd_i.wr_seq | cmd_i.wr_pick;

  wvp_ram #(.WIDTH(1), .DEPTH(SOUND_ENTRIES)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wd),
    .re_i    (cmd_i.cap_req),
    .raddr_i (addr_in),
    .rdata_o (flag_rd)
  );

  wvp_ram #(.WIDTH(ENTRY_W), .DEPTH(SOUND_ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (addr_q),
    .wdata_i (ent_wd),
    .re_i    (cmd_i.cap_req),
    .raddr_i (addr_in),
    .rdata_o (ent_rd)
  );

  // read data holds until the next transaction, so it is used in place
  assign e_lv   = ent_rd[E_LV];
  assign e_last = ent_rd[E_LAST_LO +: VW];
  assign e_nseq = ent_rd[E_NSEQ_LO +: VW];
  assign e_wts  = ent_rd[E_W_LO +: PACK_W];
  assign e_cnt  = ent_rd[E_CNT_LO +: CNT_W];
  assign e_mode = ent_rd[E_MODE_LO +: MODE_W];

  // declared count: zero means one, clamp at the variant limit
  assign cnt_ext = 5'(variant_count_i);
  always_comb begin
    cnt_clamp = cnt_ext;
    if (cnt_ext == 5'd0) begin
      cnt_clamp = 5'd1;
    end
    if (cnt_clamp > 5'(MAX_VARIANTS)) begin
      cnt_clamp = 5'(MAX_VARIANTS);
    end
  end

  // sequential mode
  always_comb begin
    seq_pick = e_nseq;
    if (CNT_W'(e_nseq) >= e_cnt) begin
      seq_pick = '0;
    end
    seq_next = seq_pick + VW'(1);
    if (CNT_W'(seq_pick) + CNT_W'(1) == e_cnt) begin
      seq_next = '0;
    end
  end

  // weight of the variant under the counter, last pick masked in no-repeat mode
  assign avoid   = (e_mode == MODE_NO_REPEAT) && (e_cnt > CNT_W'(1)) && e_lv;
  assign shamt   = 8'(32'(v_q) * WEIGHT_BITS);
  assign shifted = e_wts >> shamt;
  assign w_raw   = (shamt >= 8'(PACK_W)) ? '0 : shifted[WEIGHT_BITS-1:0];
  assign w_eff   = (avoid && (v_q == e_last)) ? '0 : w_raw;
  assign v_last  = (CNT_W'(v_q) + CNT_W'(1) == e_cnt);

  assign trial = {rem_q, rnd_q[RND_W-1]};

  always_comb begin
    ent_wd = ent_rd;
    priority if (cmd_i.wr_decl) begin
      ent_wd[E_MODE_LO +: MODE_W] = mode_in_q;
      ent_wd[E_CNT_LO +: CNT_W]   = cnt_in_q;
      ent_wd[E_W_LO +: PACK_W]    = wts_in_q;
      ent_wd[E_NSEQ_LO +: VW]     = '0;
      ent_wd[E_LAST_LO +: VW]     = '0;
      ent_wd[E_LV]                = 1'b0;
    end else if (cmd_i.wr_seq) begin
      ent_wd[E_NSEQ_LO +: VW]     = seq_next;
      ent_wd[E_LAST_LO +: VW]     = seq_pick;
      ent_wd[E_LV]                = 1'b1;
    end else begin
      ent_wd[E_LAST_LO +: VW]     = v_q;
      ent_wd[E_LV]                = 1'b1;
    end
  end

  always_comb begin
    v_d     = v_q;
    total_d = total_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    rnd_d   = rnd_q;
    priority if (cmd_i.cap_req) begin
      rnd_d = random_word_i;
    end else if (cmd_i.sum_init) begin
      v_d     = '0;
      total_d = '0;
    end else if (cmd_i.sum_step) begin
      total_d = total_q + TOT_W'(w_eff);
      v_d     = v_q + VW'(1);
    end else if (cmd_i.div_init) begin
      rem_d = '0;
      bit_d = BC_W'(RND_W - 1);
      v_d   = '0;
    end else if (cmd_i.div_step) begin
      // restoring division, one quotient bit per cycle, remainder kept
      if (trial >= {1'b0, total_q}) begin
        rem_d = TOT_W'(trial - {1'b0, total_q});
      end else begin
        rem_d = trial[TOT_W-1:0];
      end
      rnd_d = {rnd_q[RND_W-2:0], 1'b0};
      bit_d = bit_q - BC_W'(1);
    end else if (cmd_i.scan_step && !stat_o.scan_hit) begin
      rem_d = rem_q - TOT_W'(w_eff);
      v_d   = v_q + VW'(1);
    end else begin
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) begin
      req_q     <= req_type_i;
      idx_q     <= sound_index_i;
      mode_in_q <= select_mode_i;
      cnt_in_q  <= CNT_W'(cnt_clamp);
      wts_in_q  <= packed_weights_i;
    end
    rnd_q   <= rnd_d;
    v_q     <= v_d;
    total_q <= total_d;
    rem_q   <= rem_d;
    bit_q   <= bit_d;
    if (cmd_i.res_en) begin
      unique case (cmd_i.res_kind)
        RES_NOT_DECLARED: begin
          res_st_q  <= ST_NOT_DECLARED;
          res_var_q <= '0;
        end
        RES_ZERO_TOTAL: begin
          res_st_q  <= ST_ZERO_TOTAL;
          res_var_q <= '0;
        end
        RES_DECLARED: begin
          res_st_q  <= ST_OK;
          res_var_q <= '0;
        end
        RES_SEQ: begin
          res_st_q  <= ST_OK;
          res_var_q <= VAR_W'(seq_pick);
        end
        RES_SCAN: begin
          res_st_q  <= ST_OK;
          res_var_q <= VAR_W'(v_q);
        end
        default: begin
          res_st_q  <= ST_NOT_DECLARED;
          res_var_q <= '0;
        end
      endcase
    end
    if (cmd_i.load_out) begin
      out_st_q  <= res_st_q;
      out_var_q <= res_var_q;
    end
  end

  assign out_valid_d = cmd_i.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  assign stat_o.clr_last   = (clr_q == AW'(SOUND_ENTRIES - 1));
  assign stat_o.in_range   = (32'(idx_q) < SOUND_ENTRIES);
  assign stat_o.is_pick    = (req_q == REQ_PICK);
  assign stat_o.declared   = flag_rd;
  assign stat_o.mode_seq   = (e_mode == MODE_SEQ);
  assign stat_o.sum_last   = v_last;
  assign stat_o.total_zero = (total_q == '0);
  assign stat_o.div_last   = (bit_q == '0);
  assign stat_o.scan_hit   = (rem_q < TOT_W'(w_eff)) || v_last;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign picked_variant_o = out_var_q;
  assign status_o         = out_st_q;

endmodule

// ===== rtl/weighted_variant_picker.sv =====
// Top level: weighted/sequential variant picker per sound entry.
// One transaction at a time. Declare and sequential pick are answered from the lookup.
// A weighted pick takes longer; its length is set by
// the one-bit-per-cycle 64-bit modulo and the one-variant-per-cycle sum and scan.
// A new request is taken while the previous result waits in the output register.
// After reset a pass over all SOUND_ENTRIES entries clears the declared flags; no request is taken.
module weighted_variant_picker import wvp_pkg::*; #(
  parameter int SOUND_ENTRIES = SOUND_ENTRIES_DEF,
  parameter int MAX_VARIANTS  = MAX_VARIANTS_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [IDX_W-1:0]   sound_index_i,
  input  logic [MODE_W-1:0]  select_mode_i,
  input  logic [CNTIN_W-1:0] variant_count_i,
  input  logic [PACK_W-1:0]  packed_weights_i,
  input  logic [RND_W-1:0]   random_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VAR_W-1:0]   picked_variant_o,
  output logic [1:0]         status_o
);

  cmd_t  cmd;
  stat_t stat;

  wvp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wvp_dp #(
    .SOUND_ENTRIES (SOUND_ENTRIES),
    .MAX_VARIANTS  (MAX_VARIANTS),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (req_type_i),
    .sound_index_i    (sound_index_i),
    .select_mode_i    (select_mode_i),
    .variant_count_i  (variant_count_i),
    .packed_weights_i (packed_weights_i),
    .random_word_i    (random_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .picked_variant_o (picked_variant_o),
    .status_o         (status_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the weighted variant picker.
module tb_top;
  import wvp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
  localparam int N_RANDOM   = 540;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 150;

  typedef struct {
    logic              req;
    logic [IDX_W-1:0]  idx;
    logic [MODE_W-1:0] mode;
    logic [CNTIN_W-1:0] cnt;
    logic [PACK_W-1:0] weights;
    logic [RND_W-1:0]  rword;
    bit                hold;
  } sound_req_t;

  typedef struct {
    logic [VAR_W-1:0] variant;
    status_e          status;
  } pick_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = 1'b0;
  logic [IDX_W-1:0]   sound_index = '0;
  logic [MODE_W-1:0]  select_mode = '0;
  logic [CNTIN_W-1:0] variant_count = '0;
  logic [PACK_W-1:0]  packed_weights = '0;
  logic [RND_W-1:0]   random_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VAR_W-1:0]   picked_variant;
  logic [1:0]         status;

  weighted_variant_picker u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (req_type),
    .sound_index_i    (sound_index),
    .select_mode_i    (select_mode),
    .variant_count_i  (variant_count),
    .packed_weights_i (packed_weights),
    .random_word_i    (random_word),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .picked_variant_o (picked_variant),
    .status_o         (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted copy of the sound table
  bit                 tbl_declared [SOUND_ENTRIES_DEF];
  logic [MODE_W-1:0]  tbl_mode     [SOUND_ENTRIES_DEF];
  int unsigned        tbl_count    [SOUND_ENTRIES_DEF];
  logic [PACK_W-1:0]  tbl_weights  [SOUND_ENTRIES_DEF];
  logic [VAR_W-1:0]   tbl_next     [SOUND_ENTRIES_DEF];
  logic [VAR_W-1:0]   tbl_last     [SOUND_ENTRIES_DEF];
  bit                 tbl_last_ok  [SOUND_ENTRIES_DEF];

  sound_req_t req_queue[$];
  pick_res_t  expected_picks[$];
  sound_req_t cur_req;
  int         gap_left = 0;
  int         burst_left = 4;
  int         n_total = 0;
  int         n_accepted = 0;
  int         n_picks = 0;
  int         n_checked = 0;
  int         n_zero_total = 0;
  int         n_undeclared = 0;
  int         err_cnt = 0;
  int         idle_cycles = 0;
  int         cycle_cnt = 0;

  function automatic pick_res_t pick_outcome(sound_req_t r);
    pick_res_t        res;
    int unsigned      n;
    logic [VAR_W-1:0] sel;
    logic [63:0]      sum;
    logic [63:0]      draw;
    logic [63:0]      w;
    bit               skip_last;
    res.variant = '0;
    res.status  = ST_OK;
    if (r.req == REQ_DECLARE) begin
      n = 32'(r.cnt);
      if (n == 0) n = 1;
      if (n > MAX_VARIANTS_DEF) n = MAX_VARIANTS_DEF;
      tbl_mode[r.idx]     = r.mode;
      tbl_count[r.idx]    = n;
      tbl_weights[r.idx]  = r.weights;
      tbl_next[r.idx]     = '0;
      tbl_last[r.idx]     = '0;
      tbl_last_ok[r.idx]  = 1'b0;
      tbl_declared[r.idx] = 1'b1;
      return res;
    end
    if (!tbl_declared[r.idx]) begin
      res.status = ST_NOT_DECLARED;
      return res;
    end
    n = tbl_count[r.idx];
    sel = '0;
    if (tbl_mode[r.idx] == MODE_SEQ) begin
      sel = tbl_next[r.idx];
      if (sel >= n) sel = '0;
      tbl_next[r.idx] = VAR_W'((32'(sel) + 1) % n);
    end else begin
      // no-repeat mode drops the last pick's weight, but only with 2+ variants
      skip_last = tbl_mode[r.idx] == MODE_NO_REPEAT && n > 1 && tbl_last_ok[r.idx];
      sum = '0;
      for (int v = 0; v < n; v++) begin
        if (!(skip_last && v == tbl_last[r.idx]))
          sum += 64'(tbl_weights[r.idx][v*WEIGHT_BITS_DEF +: WEIGHT_BITS_DEF]);
      end
      if (sum == 0) begin
        res.status = ST_ZERO_TOTAL;
        return res;
      end
      draw = r.rword % sum;
      for (int v = 0; v < n; v++) begin
        w = (skip_last && v == tbl_last[r.idx]) ? 64'd0 :
            64'(tbl_weights[r.idx][v*WEIGHT_BITS_DEF +: WEIGHT_BITS_DEF]);
        if (draw < w) begin
          sel = VAR_W'(v);
          break;
        end
        draw -= w;
      end
    end
    tbl_last[r.idx]    = sel;
    tbl_last_ok[r.idx] = 1'b1;
    res.variant = sel;
    return res;
  endfunction

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      req_type       <= REQ_DECLARE;
      sound_index    <= '0;
      select_mode    <= '0;
      variant_count  <= '0;
      packed_weights <= '0;
      random_word    <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_picks = {expected_picks, pick_outcome(cur_req)};
        n_accepted++;
        if (cur_req.req == REQ_PICK) n_picks++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0 &&
                     !(req_queue[0].hold && expected_picks.size() != 0)) begin
          cur_req = req_queue.pop_front();
          req_type       <= cur_req.req;
          sound_index    <= cur_req.idx;
          select_mode    <= cur_req.mode;
          variant_count  <= cur_req.cnt;
          packed_weights <= cur_req.weights;
          random_word    <= cur_req.rword;
          in_valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern rotates: always ready, random, periodic, mostly ready
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      case ((cycle_cnt / 256) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cycle_cnt % 4) == 0;
        default: out_ready <= $urandom_range(0, 4) != 0;
      endcase
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: picked_variant=%0d status=%0d", picked_variant, status);
        err_cnt++;
      end else begin
        pick_res_t exp_res;
        exp_res = expected_picks.pop_front();
        n_checked++;
        if (exp_res.status == ST_ZERO_TOTAL) n_zero_total++;
        if (exp_res.status == ST_NOT_DECLARED) n_undeclared++;
        if (picked_variant !== exp_res.variant) begin
          $error("picked_variant mismatch: expected %0d, actual %0d",
                 exp_res.variant, picked_variant);
          err_cnt++;
        end
        if (status !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus generation
  bit gen_declared [SOUND_ENTRIES_DEF];
  int gen_list[$];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_weights();
    logic [63:0] w;
    int r;
    if ($urandom_range(0, 9) == 0) return rand64();
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 9);
      w[i*8 +: 8] = (r < 2) ? 8'h00 : (r == 2) ? 8'hFF : 8'($urandom_range(1, 254));
    end
    return w;
  endfunction

  function automatic logic [63:0] rand_draw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return 64'($urandom_range(0, 3000));
    return rand64();
  endfunction

  task automatic add_declare(input logic [IDX_W-1:0] idx, input logic [MODE_W-1:0] mode,
                             input logic [CNTIN_W-1:0] cnt, input logic [PACK_W-1:0] w);
    sound_req_t r;
    r = '{req: REQ_DECLARE, idx: idx, mode: mode, cnt: cnt, weights: w,
          rword: rand64(), hold: 1'b0};
    req_queue = {req_queue, r};
    if (!gen_declared[idx]) gen_list = {gen_list, int'(idx)};
    gen_declared[idx] = 1'b1;
  endtask

  task automatic add_pick(input logic [IDX_W-1:0] idx, input logic [RND_W-1:0] rw);
    sound_req_t r;
    r = '{req: REQ_PICK, idx: idx, mode: 2'($urandom), cnt: 4'($urandom),
          weights: rand64(), rword: rw, hold: 1'b0};
    req_queue = {req_queue, r};
  endtask

  initial begin
    // Directed part
    add_pick(6'd5, rand64());                                      // undeclared sound
    add_declare(6'd0, MODE_SEQ, 4'd3, rand64());
    repeat (4) add_pick(6'd0, rand64());                           // sequence wraps
    add_declare(6'd1, MODE_WEIGHTED, 4'd0, '1);                    // count zero -> one
    add_pick(6'd1, '1);
    add_declare(6'd2, MODE_SPARE, 4'd15, '1);                      // count clamped, mode 3
    add_pick(6'd2, '1);
    add_pick(6'd2, '0);
    add_declare(6'd3, MODE_WEIGHTED, 4'd8, '0);                    // zero total
    add_pick(6'd3, rand64());
    add_declare(6'd4, MODE_NO_REPEAT, 4'd2, 64'h0000_0000_0000_0500);
    add_pick(6'd4, rand64());                                      // only variant 1
    add_pick(6'd4, rand64());                                      // last masked -> zero total
    add_declare(6'd6, MODE_NO_REPEAT, 4'd1, 64'h07);               // single variant repeats
    add_pick(6'd6, rand64());
    add_pick(6'd6, rand64());
    add_declare(6'd0, MODE_SEQ, 4'd2, rand64());                   // redeclare resets sequence
    add_pick(6'd0, rand64());
    add_declare(6'd63, MODE_NO_REPEAT, 4'd8, rand_weights());
    add_pick(6'd63, '1);
    req_queue[$].hold = 1'b1;
    add_pick(6'd63, '0);

    // Random part: mostly picks on declared sounds, some noise
    for (int i = 0; i < N_RANDOM; i++) begin
      int r;
      logic [IDX_W-1:0] idx;
      r = $urandom_range(0, 99);
      if (r < 25 || gen_list.size() == 0) begin
        idx = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15)) : 6'($urandom);
        add_declare(idx, 2'($urandom),
                    ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8)),
                    rand_weights());
      end else if (r < 95) begin
        add_pick(6'(gen_list[$urandom_range(0, gen_list.size() - 1)]), rand_draw());
      end else begin
        add_pick(6'($urandom), rand_draw());
      end
      if (i % 150 == 149) req_queue[$].hold = 1'b1;
    end
    n_total = req_queue.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total || expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d requests (%0d picks); %0d results checked,", n_accepted, n_picks,
             n_checked);
    $display("%0d of them zero-total and %0d undeclared", n_zero_total, n_undeclared);
    if (err_cnt == 0 && expected_picks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
